// ----- rtl/core/ppm_ir_symbol_timing_encoder_macros.svh -----
// Assertion macros for the pulse-position IR timing encoder.
// Used by the port checker; depends on i_clk and i_rst_n in the using scope.
`ifndef PPM_IR_SYMBOL_TIMING_ENCODER_MACROS_SVH
`define PPM_IR_SYMBOL_TIMING_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppm_ir: same-cycle assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define PPM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppm_ir: next-cycle assertion failed");

`endif

// ----- rtl/core/ppm_ir_pkg.sv -----
// Shared types, constants and pause tables of the pulse-position IR encoder.
// No dependencies; imported by every module of the block.
package ppm_ir_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int SEG_CNT_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIXTEEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAP     = 1'b1;

    localparam logic [15:0] FRAME_GAP_RESET = 16'd2000;
    localparam logic [15:0] BURST_PP4_US    = 16'd40;
    localparam logic [15:0] BURST_PP16_US   = 16'd21;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] duration_us;
        logic        carrier_on;
        logic        run_end;
        logic        frame_end;
    } t_out_beat;

    // One classified byte: the pause of each symbol, already looked up.
    typedef struct packed {
        logic [3:0][7:0] pause;
        logic            wide;
        logic            final_byte;
    } t_job;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

    function automatic logic [7:0] pause4_lookup(input logic [1:0] sym);
        logic [7:0] val;
        unique case (sym)
            2'd0: val = 8'd61;
            2'd1: val = 8'd244;
            2'd2: val = 8'd122;
            2'd3: val = 8'd183;
        endcase
        return val;
    endfunction

    function automatic logic [7:0] pause16_lookup(input logic [3:0] sym);
        logic [7:0] val;
        unique case (sym)
            4'd0:  val = 8'd27;
            4'd1:  val = 8'd51;
            4'd2:  val = 8'd35;
            4'd3:  val = 8'd43;
            4'd4:  val = 8'd147;
            4'd5:  val = 8'd123;
            4'd6:  val = 8'd139;
            4'd7:  val = 8'd131;
            4'd8:  val = 8'd83;
            4'd9:  val = 8'd59;
            4'd10: val = 8'd75;
            4'd11: val = 8'd67;
            4'd12: val = 8'd91;
            4'd13: val = 8'd115;
            4'd14: val = 8'd99;
            4'd15: val = 8'd107;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/ppm_ir_front.sv -----
// Front end: accepts a byte beat and splits it into symbol pauses.
// Depends on ppm_ir_pkg.
module ppm_ir_front
    import ppm_ir_pkg::*;
(
    input  logic     i_start,
    input  t_in_beat i_in,
    input  logic     i_sixteen_level_mode,
    input  t_q_stat  i_stat,
    output logic     o_busy,
    output logic     o_push,
    output t_job     o_job
);

    assign o_busy = i_stat.full;
    assign o_push = i_start && !i_stat.full;

    // Symbols go least significant first; unused slots in 16-level mode are zero.
    always_comb begin
        o_job.wide       = i_sixteen_level_mode;
        o_job.final_byte = i_in.final_byte;
        if (i_sixteen_level_mode) begin
            o_job.pause[0] = pause16_lookup(i_in.data_byte[3:0]);
            o_job.pause[1] = pause16_lookup(i_in.data_byte[7:4]);
            o_job.pause[2] = 8'd0;
            o_job.pause[3] = 8'd0;
        end else begin
            o_job.pause[0] = pause4_lookup(i_in.data_byte[1:0]);
            o_job.pause[1] = pause4_lookup(i_in.data_byte[3:2]);
            o_job.pause[2] = pause4_lookup(i_in.data_byte[5:4]);
            o_job.pause[3] = pause4_lookup(i_in.data_byte[7:6]);
        end
    end

endmodule

// ----- rtl/core/ppm_ir_queue.sv -----
// Short job queue between the front end and the segment sequencer.
// Depends on ppm_ir_pkg.
module ppm_ir_queue
    import ppm_ir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == CNT_FULL);

endmodule

// ----- rtl/core/ppm_ir_back.sv -----
// Back end: steps through the segments of the head job, one per cycle.
// Depends on ppm_ir_pkg.
module ppm_ir_back
    import ppm_ir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  t_q_stat     i_stat,
    input  logic [15:0] i_frame_gap_us,
    output logic        o_pop,
    output logic        o_strobe,
    output t_out_beat   o_result
);

    logic [SEG_CNT_W-1:0] r_seg, n_seg;
    logic [SEG_CNT_W-1:0] sym_segs;
    logic [SEG_CNT_W-1:0] last_seg;
    logic                 seg_last;
    logic [15:0]          burst_us;
    logic                 r_strobe;
    t_out_beat            r_result, n_result;

    always_comb begin
        sym_segs = i_head.wide ? SEG_CNT_W'(4) : SEG_CNT_W'(8);
        last_seg = sym_segs - 1'b1 + (i_head.final_byte ? SEG_CNT_W'(2) : SEG_CNT_W'(0));
        seg_last = (r_seg == last_seg);
        burst_us = i_head.wide ? BURST_PP16_US : BURST_PP4_US;
        o_pop    = i_stat.not_empty && seg_last;
        n_seg    = r_seg;
        if (i_stat.not_empty) begin
            n_seg = seg_last ? '0 : r_seg + 1'b1;
        end

        // Even segments are bursts; odd ones are pauses, or the gap past the symbols.
        n_result.run_end   = seg_last;
        n_result.frame_end = 1'b0;
        if (!r_seg[0]) begin
            n_result.duration_us = burst_us;
            n_result.carrier_on  = 1'b1;
        end else if (r_seg < sym_segs) begin
            n_result.duration_us = {8'd0, i_head.pause[r_seg[2:1]]};
            n_result.carrier_on  = 1'b0;
        end else begin
            n_result.duration_us = i_frame_gap_us;
            n_result.carrier_on  = 1'b0;
            n_result.frame_end   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_seg    <= n_seg;
            r_strobe <= i_stat.not_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/core/ppm_ir_symbol_timing_encoder.sv -----
// Top level of the pulse-position IR symbol timing encoder.
// Depends on ppm_ir_pkg, ppm_ir_front, ppm_ir_queue and ppm_ir_back.
//
// A byte beat is taken at a rising edge where i_start is high and o_busy is
// low. Each byte turns into timing segments: a carrier burst and a pause for
// every symbol (four 2-bit symbols at 40 us bursts, or two 4-bit symbols at
// 21 us bursts in 16-level mode), plus a closing burst and the frame gap when
// final_byte is set. The block puts out one segment per clock on o_result,
// marked by o_strobe for exactly one cycle; the receiver cannot stall, so it
// must take every strobed beat. The one-segment-per-cycle sequencer sets the
// sustained byte rate. When the block is idle, a taken byte is first written
// into the queue, and its first segment is then registered onto o_result. A
// two-entry queue sits between the byte front end and the sequencer, so a new
// byte is taken while earlier ones are still being sent; o_busy is high only
// while that queue is full. Configuration is written through i_cfg_we /
// i_cfg_index / i_cfg_data and must only change while no byte is pending; the
// mode is sampled when a byte is taken and the gap length when its gap
// segment is sent.
module ppm_ir_symbol_timing_encoder
    import ppm_ir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_beat              i_in,
    output logic                  o_strobe,
    output t_out_beat             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic        r_sixteen_level_mode;
    logic [15:0] r_frame_gap_us;

    // Front to queue, queue to back.
    logic    push;
    logic    pop;
    t_job    front_job;
    t_job    head_job;
    t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sixteen_level_mode <= 1'b0;
            r_frame_gap_us       <= FRAME_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_SIXTEEN: r_sixteen_level_mode <= i_cfg_data[0];
                CFG_IDX_GAP:     r_frame_gap_us       <= i_cfg_data[15:0];
            endcase
        end
    end

    // The front end looks up the symbol pauses at accept time.
    ppm_ir_front u_front (
        .i_start              (i_start),
        .i_in                 (i_in),
        .i_sixteen_level_mode (r_sixteen_level_mode),
        .i_stat               (q_stat),
        .o_busy               (o_busy),
        .o_push               (push),
        .o_job                (front_job)
    );

    ppm_ir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // The sequencer retires the head job on its last segment.
    ppm_ir_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_job),
        .i_stat         (q_stat),
        .i_frame_gap_us (r_frame_gap_us),
        .o_pop          (pop),
        .o_strobe       (o_strobe),
        .o_result       (o_result)
    );

endmodule

// ----- rtl/core/ppm_ir_checker.sv -----
// Port-level checker for the pulse-position IR encoder, bound to the top level.
// Depends on ppm_ir_pkg and ppm_ir_symbol_timing_encoder_macros.svh.
`include "ppm_ir_symbol_timing_encoder_macros.svh"

module ppm_ir_checker
    import ppm_ir_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_strobe,
    input t_out_beat o_result
);

    // The frame gap always closes the run of its byte.
    `PPM_ASSERT_IMP(a_gap_ends_run, o_strobe && o_result.frame_end, o_result.run_end)
    // A burst is never the last segment of a byte.
    `PPM_ASSERT_IMP(a_burst_not_last, o_strobe && o_result.carrier_on, !o_result.run_end)
    // The frame gap is an idle segment.
    `PPM_ASSERT_IMP(a_gap_idle, o_strobe && o_result.frame_end, !o_result.carrier_on)
    // Every burst is followed at once by its pause or gap.
    `PPM_ASSERT_NXT(a_burst_then_pause, o_strobe && o_result.carrier_on, o_strobe && !o_result.carrier_on)

endmodule

bind ppm_ir_symbol_timing_encoder ppm_ir_checker u_checker (.*);

// ----- tb/ppm_ir_symbol_timing_encoder_tb.sv -----
// Self-checking testbench for the pulse-position IR symbol timing encoder.
// Depends on ppm_ir_pkg and the ppm_ir_symbol_timing_encoder RTL; it reads no files.
// Directed table first, then random phases over several register settings.
`timescale 1ns / 100ps

module ppm_ir_symbol_timing_encoder_tb;
    import ppm_ir_pkg::*;

    localparam int N_DIRECTED      = 20;
    localparam int RANDOM_PHASES   = 5;
    localparam int BYTES_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 4;       // idle edges waited after the block drains
    localparam int TAIL_CYCLES     = 20;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PRINT_CAP       = 40;
    localparam int IDLE_PERCENT    = 27;

    // Pause tables in microseconds. Packed, so element 0 is the last one listed.
    localparam logic [3:0][15:0] PAUSE4_US = {16'd183, 16'd122, 16'd244, 16'd61};
    localparam logic [15:0][15:0] PAUSE16_US = {
        16'd107, 16'd99, 16'd115, 16'd91, 16'd67, 16'd75, 16'd59, 16'd83,
        16'd131, 16'd139, 16'd123, 16'd147, 16'd43, 16'd35, 16'd51, 16'd27};

    // One row of the directed table. Where known is set, the first pause and the
    // duration of the last segment of the byte are typed in, read off the tables.
    typedef struct packed {
        logic [15:0] mode_word;
        logic [15:0] gap_word;
        logic [7:0]  data_byte;
        logic        final_byte;
        logic        known;
        logic [15:0] pause0_us;
        logic [15:0] last_us;
    } t_directed_row;

    // The first rows run on the reset settings without any register write.
    // The symbol orders of 0xE4 and 0x1B show the least significant symbol goes
    // first; zero and all-ones frame gaps and the mode bit written with junk in
    // the upper data bits are covered as well.
    t_directed_row directed_rows [0:N_DIRECTED-1] = '{
        '{16'd0,      16'd2000,  8'h00, 1'b0, 1'b1, 16'd61,  16'd61},
        '{16'd0,      16'd2000,  8'hFF, 1'b0, 1'b1, 16'd183, 16'd183},
        '{16'd0,      16'd2000,  8'hE4, 1'b1, 1'b1, 16'd61,  16'd2000},
        '{16'd0,      16'd2000,  8'h1B, 1'b0, 1'b1, 16'd183, 16'd61},
        '{16'd0,      16'd2000,  8'h55, 1'b1, 1'b1, 16'd244, 16'd2000},
        '{16'd1,      16'd0,     8'h00, 1'b1, 1'b1, 16'd27,  16'd0},
        '{16'd1,      16'd0,     8'hFF, 1'b0, 1'b1, 16'd107, 16'd107},
        '{16'd1,      16'd0,     8'h10, 1'b0, 1'b1, 16'd27,  16'd51},
        '{16'd1,      16'd0,     8'h32, 1'b1, 1'b0, 16'd0,   16'd0},
        '{16'd1,      16'd0,     8'h54, 1'b0, 1'b0, 16'd0,   16'd0},
        '{16'd1,      16'd0,     8'h76, 1'b1, 1'b0, 16'd0,   16'd0},
        '{16'd1,      16'd0,     8'h98, 1'b0, 1'b0, 16'd0,   16'd0},
        '{16'd1,      16'd0,     8'hBA, 1'b1, 1'b0, 16'd0,   16'd0},
        '{16'd1,      16'd0,     8'hDC, 1'b0, 1'b0, 16'd0,   16'd0},
        '{16'd1,      16'd0,     8'hFE, 1'b1, 1'b0, 16'd0,   16'd0},
        '{16'd1,      16'hFFFF,  8'hA5, 1'b1, 1'b1, 16'd123, 16'hFFFF},
        '{16'd1,      16'hFFFF,  8'h5A, 1'b1, 1'b0, 16'd0,   16'd0},
        '{16'hFFFE,   16'd1,     8'hC3, 1'b1, 1'b1, 16'd183, 16'd1},
        '{16'hFFFE,   16'd1,     8'h3C, 1'b0, 1'b1, 16'd61,  16'd61},
        '{16'hFFFF,   16'd2000,  8'h81, 1'b1, 1'b1, 16'd51,  16'd2000}
    };

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    logic                  o_busy;
    t_in_beat              i_in        = '0;
    logic                  o_strobe;
    t_out_beat             o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_IDX_SIXTEEN;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Our own copy of the two registers, updated at the edge that writes them.
    logic        mode_wide = 1'b0;
    logic [15:0] gap_us    = FRAME_GAP_RESET;
    logic [15:0] mode_word_now = 16'd0;
    logic [15:0] gap_word_now  = FRAME_GAP_RESET;

    t_out_beat   pending_segments [$];  // segments still owed by the block, oldest first
    t_out_beat   byte_segments [0:9];   // the segments of the byte just taken
    int          byte_segment_count;

    int          error_count    = 0;
    int          cycle_count    = 0;
    int          bytes_sent     = 0;
    int          frames_closed  = 0;
    int          segments_seen  = 0;
    int          settings_used  = 1;

    ppm_ir_symbol_timing_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every failure goes through here: one line each, capped so a broken block
    // cannot flood the log, but always counted.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    // Works out the timing segments one byte turns into under the current
    // settings: a burst and a pause per symbol, low symbol first, and for the
    // last byte of a frame a closing burst plus the frame gap. The run-end mark
    // sits on the final segment of the byte, whichever that is.
    function automatic int encode_byte_segments(input t_in_beat beat);
        logic [7:0]  rest;
        logic [15:0] burst;
        logic [15:0] pause;
        int          n;
        int          symbols;
        rest    = beat.data_byte;
        burst   = mode_wide ? BURST_PP16_US : BURST_PP4_US;
        symbols = mode_wide ? 2 : 4;
        n       = 0;
        for (int s = 0; s < symbols; s++) begin
            if (mode_wide) begin
                pause = PAUSE16_US[rest[3:0]];
                rest  = rest >> 4;
            end else begin
                pause = PAUSE4_US[rest[1:0]];
                rest  = rest >> 2;
            end
            byte_segments[n] = '{duration_us: burst, carrier_on: 1'b1,
                                 run_end: 1'b0, frame_end: 1'b0};
            n++;
            byte_segments[n] = '{duration_us: pause, carrier_on: 1'b0,
                                 run_end: 1'b0, frame_end: 1'b0};
            n++;
        end
        if (beat.final_byte) begin
            byte_segments[n] = '{duration_us: burst, carrier_on: 1'b1,
                                 run_end: 1'b0, frame_end: 1'b0};
            n++;
            byte_segments[n] = '{duration_us: gap_us, carrier_on: 1'b0,
                                 run_end: 1'b1, frame_end: 1'b1};
            n++;
        end else begin
            byte_segments[n-1].run_end = 1'b1;
        end
        return n;
    endfunction

    // Offers one byte beat and holds it until the block takes it. With idling
    // allowed, the sender first sits out a random number of cycles, each one
    // with the same chance, so gaps land on every phase of the block's work.
    // Only one assignment to i_start happens in any time step.
    task automatic send_byte(input t_in_beat beat, input bit may_idle);
        while (may_idle && ($urandom_range(99) < IDLE_PERCENT)) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= beat;
        do begin
            @(posedge i_clk);
        end while (o_busy !== 1'b0);
        // Taken at this edge: the mode in force now decides the encoding.
        byte_segment_count = encode_byte_segments(beat);
        for (int k = 0; k < byte_segment_count; k++) begin
            pending_segments.push_back(byte_segments[k]);
        end
        bytes_sent++;
        if (beat.final_byte) begin
            frames_closed++;
        end
    endtask

    // Stops offering bytes and waits until the block owes nothing, then lets the
    // pipeline settle.
    task automatic wait_for_drain();
        i_start <= 1'b0;
        while (pending_segments.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back edges once the block is idle.
    // The enable stays high across both so it is never dropped and raised in
    // the same step.
    task automatic program_registers(input logic [15:0] mode_word,
                                     input logic [15:0] gap_word);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_SIXTEEN;
        i_cfg_data  <= mode_word;
        @(posedge i_clk);
        mode_wide     = mode_word[0];
        mode_word_now = mode_word;
        i_cfg_index <= CFG_IDX_GAP;
        i_cfg_data  <= gap_word;
        @(posedge i_clk);
        gap_us       = gap_word;
        gap_word_now = gap_word;
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Result checker. A strobed segment is taken at the edge that ends its
    // cycle; the block cannot be stalled, so every strobe is compared against
    // the oldest segment still owed.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                report_mismatch("result strobe is unknown");
            end else if (o_strobe) begin
                segments_seen++;
                if (pending_segments.size() == 0) begin
                    report_mismatch($sformatf(
                        "segment with nothing owed: duration %0d carrier %0d",
                        o_result.duration_us, o_result.carrier_on));
                end else begin
                    want = pending_segments.pop_front();
                    if (o_result.duration_us !== want.duration_us) begin
                        report_mismatch($sformatf("duration_us got %0d, want %0d",
                            o_result.duration_us, want.duration_us));
                    end
                    if (o_result.carrier_on !== want.carrier_on) begin
                        report_mismatch($sformatf("carrier_on got %0b, want %0b",
                            o_result.carrier_on, want.carrier_on));
                    end
                    if (o_result.run_end !== want.run_end) begin
                        report_mismatch($sformatf("run_end got %0b, want %0b",
                            o_result.run_end, want.run_end));
                    end
                    if (o_result.frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("frame_end got %0b, want %0b",
                            o_result.frame_end, want.frame_end));
                    end
                end
            end
        end
    end

    // Watchdog: a hung block or a lost segment ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d segments still owed",
                 cycle_count, pending_segments.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence: reset, the directed table, then random phases.
    initial begin
        t_in_beat    beat;
        logic [15:0] mode_word;
        logic [15:0] gap_word;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. A row that asks for other settings first waits for
        // the block to drain and then writes the registers. Rows with the same
        // settings go back to back, which fills the queue and raises busy.
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].mode_word != mode_word_now ||
                directed_rows[r].gap_word != gap_word_now) begin
                program_registers(directed_rows[r].mode_word,
                                  directed_rows[r].gap_word);
            end
            beat.data_byte  = directed_rows[r].data_byte;
            beat.final_byte = directed_rows[r].final_byte;
            send_byte(beat, 1'b0);
            if (directed_rows[r].known) begin
                if (byte_segments[1].duration_us != directed_rows[r].pause0_us ||
                    byte_segments[byte_segment_count-1].duration_us !=
                        directed_rows[r].last_us) begin
                    report_mismatch($sformatf("directed row %0d disagrees with its table entry",
                        r));
                end
            end
        end

        // Random phases. Even phases run 4-level and odd ones 16-level, with
        // junk in the unused upper bits of the mode word. The first two phases
        // take the gap extremes. Phase 2 runs without any sender idling to keep
        // the queue full, and phase 3 pauses halfway until everything is out.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode_word = (16'($urandom_range(65535)) & 16'hFFFE) | 16'(p % 2);
            case (p)
                0:       gap_word = 16'hFFFF;
                1:       gap_word = 16'h0000;
                default: gap_word = 16'($urandom_range(65535));
            endcase
            program_registers(mode_word, gap_word);
            for (int i = 0; i < BYTES_PER_PHASE; i++) begin
                if (p == 3 && i == BYTES_PER_PHASE / 2) begin
                    wait_for_drain();
                end
                beat.data_byte  = 8'($urandom_range(255));
                beat.final_byte = ($urandom_range(3) == 0);
                send_byte(beat, p != 2);
            end
        end

        // Let everything owed come out, then watch a little longer for strays.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_segments.size() != 0) begin
            report_mismatch($sformatf("%0d segments never arrived",
                                      pending_segments.size()));
        end

        $display("Covered %0d bytes closing %0d frames under %0d register settings,",
                 bytes_sent, frames_closed, settings_used);
        $display("with %0d timing segments compared and %0d mismatches in %0d cycles.",
                 segments_seen, error_count, cycle_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
